### design/obpp_pkg.sv
// package for the oriented box point push-out block
// field widths, default parameter values and the structs passed between modules
// no dependencies
package obpp_pkg;

  localparam int POS_W           = 25;
  localparam int TRIG_W          = 16;
  localparam int BOX_W           = 16;
  localparam int RAD_W           = 15;
  localparam int OUT_W           = 26;
  localparam int GROW_W          = BOX_W + 1;
  localparam int DIFF_W          = POS_W + 1;
  localparam int PROD_W          = DIFF_W + TRIG_W;
  localparam int SUM_W           = PROD_W + 1;
  localparam int LOC_W           = GROW_W;
  localparam int BPROD_W         = LOC_W + TRIG_W;
  localparam int BSUM_W          = BPROD_W + 1;
  localparam int IN_DATA_W       = 216;
  localparam int OUT_DATA_W      = 56;
  localparam int TRIG_SHIFT_DEF  = 14;
  localparam int QUEUE_DEPTH_DEF = 8;

  typedef struct packed {
    logic        [RAD_W-1:0]  grow_radius;
    logic signed [BOX_W-1:0]  box_max_z;
    logic signed [BOX_W-1:0]  box_min_z;
    logic signed [BOX_W-1:0]  box_max_x;
    logic signed [BOX_W-1:0]  box_min_x;
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [POS_W-1:0]  point_z;
    logic signed [POS_W-1:0]  point_x;
    logic signed [POS_W-1:0]  obj_z;
    logic signed [POS_W-1:0]  obj_x;
  } query_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  obj_x;
    logic signed [POS_W-1:0]  obj_z;
    logic signed [POS_W-1:0]  point_x;
    logic signed [POS_W-1:0]  point_z;
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [LOC_W-1:0]  loc_x;
    logic signed [LOC_W-1:0]  loc_z;
    logic                     in_box;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] new_x;
    logic signed [OUT_W-1:0] new_z;
    logic                    pushed;
  } result_t;

endpackage

### design/oriented_box_point_pushout.sv
// oriented box point push-out, top level; uses obpp_pkg, obpp_front, obpp_queue, obpp_back
// path: the front stage registers, the queue, then the back stage and output registers to m_tvalid
// throughput: one query per cycle; the front holds up to QUEUE_DEPTH queries in flight
// (front stages plus queue), so s_tready drops only while the output side stalls
// reset: synchronous, active high; clears all valid flags, the queue and the credit count
module oriented_box_point_pushout
  import obpp_pkg::*;
#(
  parameter int TRIG_SHIFT  = TRIG_SHIFT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // obj_x, obj_z, point_x, point_z, cos_yaw, sin_yaw, box_min_x, box_max_x,
  // box_min_z, box_max_z, grow_radius, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // new_x, new_z, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // pushed
  output logic                  m_tuser
);

  localparam int QUERY_W = $bits(query_t);

  query_t  query;
  logic    wr_valid;
  item_t   wr_item;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t result;

  assign query = query_t'(s_tdata[QUERY_W-1:0]);

  obpp_front #(
    .TRIG_SHIFT  (TRIG_SHIFT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_query (query),
    .pop      (q_pop),
    .wr_valid (wr_valid),
    .wr_item  (wr_item)
  );

  obpp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_item  (wr_item),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .rd_pop   (q_pop)
  );

  obpp_back #(
    .TRIG_SHIFT (TRIG_SHIFT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {(OUT_DATA_W - 2 * OUT_W)'(0), result.new_z, result.new_x};
  assign m_tuser = result.pushed;

endmodule

### design/obpp_front.sv
// front part: accepts queries, rotates the point into the box frame and classifies it
// picks the nearest grown edge and hands a queue item on; uses obpp_pkg
module obpp_front
  import obpp_pkg::*;
#(
  parameter int TRIG_SHIFT  = TRIG_SHIFT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  query_t in_query,
  input  logic   pop,
  output logic   wr_valid,
  output item_t  wr_item
);

  localparam int RW  = SUM_W - TRIG_SHIFT;
  localparam int OCW = $clog2(QUEUE_DEPTH + 1);

  logic [OCW-1:0] occ;
  logic           accept;

  // stage 1
  logic                     v1;
  logic signed [DIFF_W-1:0] dx1, dz1;
  logic signed [GROW_W-1:0] mnx1, mxx1, mnz1, mxz1;
  logic signed [POS_W-1:0]  ox1, oz1, px1, pz1;
  logic signed [TRIG_W-1:0] c1, s1;

  // stage 2
  logic                     v2;
  logic signed [PROD_W-1:0] cdx2, sdz2, sdx2, cdz2;
  logic signed [GROW_W-1:0] mnx2, mxx2, mnz2, mxz2;
  logic signed [POS_W-1:0]  ox2, oz2, px2, pz2;
  logic signed [TRIG_W-1:0] c2, s2;

  // stage 3
  logic                     v3;
  logic signed [RW-1:0]     rx3, rz3;
  logic signed [GROW_W-1:0] mnx3, mxx3, mnz3, mxz3;
  logic signed [POS_W-1:0]  ox3, oz3, px3, pz3;
  logic signed [TRIG_W-1:0] c3, s3;

  logic signed [SUM_W-1:0]  rx_sum, rz_sum, rx_sh, rz_sh;
  logic                     in_box;
  logic        [LOC_W-1:0]  dl, dr, df, dn;
  logic signed [LOC_W-1:0]  loc_x, loc_z;

  assign accept   = in_valid && in_ready;
  assign in_ready = (occ < OCW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCW'(accept) - OCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx1  <= DIFF_W'(in_query.point_x) - DIFF_W'(in_query.obj_x);
    dz1  <= DIFF_W'(in_query.point_z) - DIFF_W'(in_query.obj_z);
    mnx1 <= GROW_W'(in_query.box_min_x) - $signed({2'b00, in_query.grow_radius});
    mxx1 <= GROW_W'(in_query.box_max_x) + $signed({2'b00, in_query.grow_radius});
    mnz1 <= GROW_W'(in_query.box_min_z) - $signed({2'b00, in_query.grow_radius});
    mxz1 <= GROW_W'(in_query.box_max_z) + $signed({2'b00, in_query.grow_radius});
    ox1  <= in_query.obj_x;
    oz1  <= in_query.obj_z;
    px1  <= in_query.point_x;
    pz1  <= in_query.point_z;
    c1   <= in_query.cos_yaw;
    s1   <= in_query.sin_yaw;
  end

  always_ff @(posedge clk) begin
    cdx2 <= c1 * dx1;
    sdz2 <= s1 * dz1;
    sdx2 <= s1 * dx1;
    cdz2 <= c1 * dz1;
    mnx2 <= mnx1;
    mxx2 <= mxx1;
    mnz2 <= mnz1;
    mxz2 <= mxz1;
    ox2  <= ox1;
    oz2  <= oz1;
    px2  <= px1;
    pz2  <= pz1;
    c2   <= c1;
    s2   <= s1;
  end

  // floor shift into the box frame
  assign rx_sum = SUM_W'(cdx2) - SUM_W'(sdz2);
  assign rz_sum = SUM_W'(sdx2) + SUM_W'(cdz2);
  assign rx_sh  = rx_sum >>> TRIG_SHIFT;
  assign rz_sh  = rz_sum >>> TRIG_SHIFT;

  always_ff @(posedge clk) begin
    rx3  <= rx_sh[RW-1:0];
    rz3  <= rz_sh[RW-1:0];
    mnx3 <= mnx2;
    mxx3 <= mxx2;
    mnz3 <= mnz2;
    mxz3 <= mxz2;
    ox3  <= ox2;
    oz3  <= oz2;
    px3  <= px2;
    pz3  <= pz2;
    c3   <= c2;
    s3   <= s2;
  end

  assign in_box = (rx3 >= RW'(mnx3)) && (rx3 <= RW'(mxx3)) &&
                  (rz3 >= RW'(mnz3)) && (rz3 <= RW'(mxz3));

  // distances are exact only when inside, which is the only case they are used
  assign dl = rx3[LOC_W-1:0] - mnx3;
  assign dr = mxx3 - rx3[LOC_W-1:0];
  assign df = mxz3 - rz3[LOC_W-1:0];
  assign dn = rz3[LOC_W-1:0] - mnz3;

  // nearest edge, ties go left, right, far, near
  always_comb begin
    loc_x = rx3[LOC_W-1:0];
    loc_z = rz3[LOC_W-1:0];
    if (dl <= dr && dl <= df && dl <= dn) begin
      loc_x = mnx3;
    end else if (dr <= dl && dr <= df && dr <= dn) begin
      loc_x = mxx3;
    end else if (df <= dl && df <= dr && df <= dn) begin
      loc_z = mxz3;
    end else begin
      loc_z = mnz3;
    end
  end

  assign wr_valid        = v3;
  assign wr_item.obj_x   = ox3;
  assign wr_item.obj_z   = oz3;
  assign wr_item.point_x = px3;
  assign wr_item.point_z = pz3;
  assign wr_item.cos_yaw = c3;
  assign wr_item.sin_yaw = s3;
  assign wr_item.loc_x   = loc_x;
  assign wr_item.loc_z   = loc_z;
  assign wr_item.in_box  = in_box;

endmodule

### design/obpp_queue.sv
// short queue between the front and back parts
// register array with a fill count; uses obpp_pkg for the item type
module obpp_queue
  import obpp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  input  item_t wr_item,
  output logic  rd_valid,
  output item_t rd_item,
  input  logic  rd_pop
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem [QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(wr_valid) - CW'(rd_pop);
    end
  end

endmodule

### design/obpp_back.sv
// back part: rotates the pushed local point back to world and holds the result
// two stages with a shared stall; uses obpp_pkg
module obpp_back
  import obpp_pkg::*;
#(
  parameter int TRIG_SHIFT = TRIG_SHIFT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic                      advance;
  logic                      b1_valid;
  logic signed [BPROD_W-1:0] zs1, xc1, zc1, xs1;
  logic signed [POS_W-1:0]   ox1, oz1, px1, pz1;
  logic                      in_box1;

  logic signed [BSUM_W-1:0]  sx, sz, shx, shz, nx, nz;

  assign advance = !out_valid || out_ready;
  assign q_pop   = q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      b1_valid  <= q_valid;
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zs1     <= q_item.loc_z * q_item.sin_yaw;
      xc1     <= q_item.loc_x * q_item.cos_yaw;
      zc1     <= q_item.loc_z * q_item.cos_yaw;
      xs1     <= q_item.loc_x * q_item.sin_yaw;
      ox1     <= q_item.obj_x;
      oz1     <= q_item.obj_z;
      px1     <= q_item.point_x;
      pz1     <= q_item.point_z;
      in_box1 <= q_item.in_box;
    end
  end

  assign sx  = BSUM_W'(zs1) + BSUM_W'(xc1);
  assign sz  = BSUM_W'(zc1) - BSUM_W'(xs1);
  assign shx = sx >>> TRIG_SHIFT;
  assign shz = sz >>> TRIG_SHIFT;
  assign nx  = shx + BSUM_W'(ox1);
  assign nz  = shz + BSUM_W'(oz1);

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result.pushed <= in_box1;
      if (in_box1) begin
        out_result.new_x <= nx[OUT_W-1:0];
        out_result.new_z <= nz[OUT_W-1:0];
      end else begin
        out_result.new_x <= OUT_W'(px1);
        out_result.new_z <= OUT_W'(pz1);
      end
    end
  end

endmodule

### bench/oriented_box_point_pushout_chk.sv
// checker for the oriented box point push-out block: predicts each result from the
// input transfers and compares it with the output transfers; depends on obpp_pkg
`timescale 1ns / 1ps

module oriented_box_point_pushout_chk
  import obpp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  output int                    errors,
  output int                    pending
);

  result_t pending_results[$];
  result_t want;
  result_t got;

  function automatic result_t predict_pushout(query_t q);
    longint ox, oz, px, pz, c, s, rad;
    longint gmnx, gmxx, gmnz, gmxz;
    longint lx, lz, dl, dr, df, dn, nx, nz;
    result_t r;
    ox   = longint'($signed(q.obj_x));
    oz   = longint'($signed(q.obj_z));
    px   = longint'($signed(q.point_x));
    pz   = longint'($signed(q.point_z));
    c    = longint'($signed(q.cos_yaw));
    s    = longint'($signed(q.sin_yaw));
    rad  = longint'({1'b0, q.grow_radius});
    gmnx = longint'($signed(q.box_min_x)) - rad;
    gmxx = longint'($signed(q.box_max_x)) + rad;
    gmnz = longint'($signed(q.box_min_z)) - rad;
    gmxz = longint'($signed(q.box_max_z)) + rad;
    lx   = (c * (px - ox) - s * (pz - oz)) >>> TRIG_SHIFT_DEF;
    lz   = (s * (px - ox) + c * (pz - oz)) >>> TRIG_SHIFT_DEF;
    nx   = px;
    nz   = pz;
    r.pushed = 1'b0;
    if (lx >= gmnx && lx <= gmxx && lz >= gmnz && lz <= gmxz) begin
      dl = lx - gmnx;
      dr = gmxx - lx;
      df = gmxz - lz;
      dn = lz - gmnz;
      // nearest edge wins; ties go left, right, far, near
      if (dl <= dr && dl <= df && dl <= dn) begin
        lx = gmnx;
      end else if (dr <= df && dr <= dn) begin
        lx = gmxx;
      end else if (df <= dn) begin
        lz = gmxz;
      end else begin
        lz = gmnz;
      end
      nx = ox + ((lz * s + lx * c) >>> TRIG_SHIFT_DEF);
      nz = oz + ((lz * c - lx * s) >>> TRIG_SHIFT_DEF);
      r.pushed = 1'b1;
    end
    r.new_x = nx[OUT_W-1:0];
    r.new_z = nz[OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_pushout(s_tdata[$bits(query_t)-1:0]));
      end
      if (m_tvalid && m_tready) begin
        got.new_x  = m_tdata[OUT_W-1:0];
        got.new_z  = m_tdata[2*OUT_W-1:OUT_W];
        got.pushed = m_tuser;
        if (pending_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("unexpected result transfer: new_x=%0d new_z=%0d pushed=%0b",
                     got.new_x, got.new_z, got.pushed);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.new_x !== want.new_x || got.new_z !== want.new_z ||
              got.pushed !== want.pushed) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("mismatch at %0t: expected new_x=%0d new_z=%0d pushed=%0b, got new_x=%0d new_z=%0d pushed=%0b",
                       $realtime, want.new_x, want.new_z, want.pushed,
                       got.new_x, got.new_z, got.pushed);
            end
          end
        end
      end
      pending = pending_results.size();
    end
  end

endmodule

### bench/oriented_box_point_pushout_tb.sv
// top of the testbench for oriented_box_point_pushout: directed and random queries under
// several idle and stall patterns; depends on obpp_pkg, the block and the checker
`timescale 1ns / 1ps

module oriented_box_point_pushout_tb;
  import obpp_pkg::*;

  localparam int ONE        = 1 << TRIG_SHIFT_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  int                    errors;
  int                    pending;
  int                    src_idle_pct = 0;
  int                    sink_stall_pct = 0;
  int                    cycle_count = 0;

  always #10 clk = ~clk;

  oriented_box_point_pushout dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  oriented_box_point_pushout_chk chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  always @(negedge clk) begin
    m_tready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // entered and left at a falling edge; tvalid stays high on return
  task automatic send_query(input query_t q);
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - $bits(query_t)){1'b0}}, q};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_fields(input int ox, oz, px, pz, c, s, mnx, mxx, mnz, mxz, rad);
    query_t q;
    q.obj_x       = ox[POS_W-1:0];
    q.obj_z       = oz[POS_W-1:0];
    q.point_x     = px[POS_W-1:0];
    q.point_z     = pz[POS_W-1:0];
    q.cos_yaw     = c[TRIG_W-1:0];
    q.sin_yaw     = s[TRIG_W-1:0];
    q.box_min_x   = mnx[BOX_W-1:0];
    q.box_max_x   = mxx[BOX_W-1:0];
    q.box_min_z   = mnz[BOX_W-1:0];
    q.box_max_z   = mxz[BOX_W-1:0];
    q.grow_radius = rad[RAD_W-1:0];
    send_query(q);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic pick_span(output int lo, output int hi);
    int a, b, cen, half;
    if ($urandom_range(0, 4) == 0) begin
      a  = int'($urandom_range(0, 65535)) - 32768;
      b  = int'($urandom_range(0, 65535)) - 32768;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
    end else begin
      cen  = int'($urandom_range(0, 40000)) - 20000;
      half = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 20))
                                         : int'($urandom_range(0, 2000));
      lo = cen - half;
      hi = cen + half;
    end
  endtask

  function automatic int clamp_pos(longint v);
    if (v > 16777215) return 16777215;
    if (v < -16777216) return -16777216;
    return int'(v);
  endfunction

  task automatic send_random();
    int kind, ox, oz, c, s, mnx, mxx, mnz, mxz, rad, lx, lz;
    longint px, pz;
    real ang;
    query_t q;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      q.obj_x       = POS_W'($urandom);
      q.obj_z       = POS_W'($urandom);
      q.point_x     = POS_W'($urandom);
      q.point_z     = POS_W'($urandom);
      q.cos_yaw     = TRIG_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
      q.sin_yaw     = TRIG_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
      q.box_min_x   = BOX_W'($urandom);
      q.box_max_x   = BOX_W'($urandom);
      q.box_min_z   = BOX_W'($urandom);
      q.box_max_z   = BOX_W'($urandom);
      q.grow_radius = RAD_W'($urandom);
      send_query(q);
    end else begin
      ox = int'($urandom_range(0, 33292288)) - 16646144;
      oz = int'($urandom_range(0, 33292288)) - 16646144;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: begin c = ONE;  s = 0;    end
          1: begin c = 0;    s = ONE;  end
          2: begin c = -ONE; s = 0;    end
          default: begin c = 0; s = -ONE; end
        endcase
      end else begin
        ang = real'($urandom_range(0, 359999)) * 6.283185307179586 / 360000.0;
        c   = int'(real'(ONE) * $cos(ang));
        s   = int'(real'(ONE) * $sin(ang));
      end
      pick_span(mnx, mxx);
      pick_span(mnz, mxz);
      rad = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 32767))
                                        : int'($urandom_range(0, 300));
      lx = int'($urandom_range(0, mxx - mnx + 2 * rad)) + mnx - rad;
      lz = int'($urandom_range(0, mxz - mnz + 2 * rad)) + mnz - rad;
      // a share lands just past an edge
      if (kind < 32) begin
        if ($urandom_range(0, 1) == 1) lx = mxx + rad + int'($urandom_range(1, 8));
        else lz = mnz - rad - int'($urandom_range(1, 8));
      end
      px = longint'(ox) + ((longint'(c) * lx + longint'(s) * lz) >>> TRIG_SHIFT_DEF);
      pz = longint'(oz) + ((longint'(c) * lz - longint'(s) * lx) >>> TRIG_SHIFT_DEF);
      send_fields(ox, oz, clamp_pos(px), clamp_pos(pz), c, s, mnx, mxx, mnz, mxz, rad);
    end
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (n) send_random();
    wait_drained();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ties: all four, right over far, far over near, left over near; also a plain right, far and near
    send_fields(0, 0, 0, 0, ONE, 0, -10, 10, -10, 10, 0);
    send_fields(100, 200, 107, 200, ONE, 0, -10, 10, -10, 10, 0);
    send_fields(0, 0, 0, 6, ONE, 0, -10, 10, -10, 10, 0);
    send_fields(0, 0, 0, -6, ONE, 0, -10, 10, -10, 10, 0);
    send_fields(0, 0, 5, 5, ONE, 0, -10, 10, -10, 10, 0);
    send_fields(0, 0, 0, 0, ONE, 0, -100, 100, -10, 10, 0);
    send_fields(0, 0, -5, -5, ONE, 0, -10, 10, -10, 10, 0);
    // outside, on the grown edge, inverted boxes
    send_fields(0, 0, 50, 0, ONE, 0, -10, 10, -10, 10, 0);
    send_fields(0, 0, -13, 0, ONE, 0, -10, 10, -10, 10, 3);
    send_fields(0, 0, 0, 0, ONE, 0, 10, -10, -10, 10, 2);
    send_fields(0, 0, 0, 0, ONE, 0, 5, -5, -5, 5, 5);
    // widest grown box, extreme positions and trig values
    send_fields(0, 0, 0, 0, ONE, 0, -32768, 32767, -32768, 32767, 32767);
    send_fields(16777215, -16777216, -16777216, 16777215, ONE, -ONE,
                -32768, 32767, -32768, 32767, 32767);
    send_fields(-16777216, 0, 16777215, 0, ONE, 0, -32768, 32767, -32768, 32767, 32767);
    send_fields(1000, 1000, 1300, 1040, 0, -ONE, -500, 500, -500, 500, 0);
    send_fields(-5000, 7000, -5100, 7020, -ONE, 0, -200, 200, -50, 50, 10);
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(16777215, 16777215, 16777215, 16777215, ONE, ONE,
                32767, 32767, 32767, 32767, 32767);
    send_fields(-16777216, -16777216, -16777216, -16777216, -ONE, -ONE,
                -32768, -32768, -32768, -32768, 0);
    // negative products where the floor matters, and a 45 degree yaw
    send_fields(0, 0, -1, 0, 5461, 9000, -10, 10, -10, 10, 0);
    send_fields(300, -300, 310, -290, 11585, 11585, -40, 40, -20, 20, 4);
    // hold off until every result has come back
    wait_drained();

    run_phase(190, 0, 0);
    run_phase(190, 75, 0);
    run_phase(190, 0, 75);
    run_phase(190, 28, 28);

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
